// ===== rtl/t0as_pkg.sv =====
// Shared types and constants for the T=0 APDU splitter.
// Used by t0as_step and t0_apdu_splitter; depends on nothing.
package t0as_pkg;

   localparam int MAX_APDU_LEN = 512;
   localparam int LEN_CAP_INT  = (MAX_APDU_LEN > 1023) ? 1023 : MAX_APDU_LEN;
   localparam logic [9:0] LEN_CAP = 10'(LEN_CAP_INT);
   localparam logic [7:0] NULL_BYTE = 8'h60;

   typedef enum logic [1:0] {
      MODE_BYTE     = 2'd0,
      MODE_BOUNDARY = 2'd1,
      MODE_RESET    = 2'd2
   } mode_type;

   typedef enum logic [8:0] {
      PH_CLA      = 9'b000000001,
      PH_INS      = 9'b000000010,
      PH_P1       = 9'b000000100,
      PH_P2       = 9'b000001000,
      PH_P3       = 9'b000010000,
      PH_PROC     = 9'b000100000,
      PH_DATA     = 9'b001000000,
      PH_DATA_ONE = 9'b010000000,
      PH_SW2      = 9'b100000000
   } phase_type;

   typedef enum logic [3:0] {
      ROLE_CLA     = 4'd0,
      ROLE_INS     = 4'd1,
      ROLE_P1      = 4'd2,
      ROLE_P2      = 4'd3,
      ROLE_P3      = 4'd4,
      ROLE_DATA    = 4'd5,
      ROLE_NULL    = 4'd6,
      ROLE_ACK_ALL = 4'd7,
      ROLE_ACK_ONE = 4'd8,
      ROLE_SW1     = 4'd9,
      ROLE_SW2     = 4'd10,
      ROLE_NONE    = 4'd11
   } role_type;

   typedef struct packed {
      phase_type  phase;
      logic [7:0] ins;
      logic [7:0] remaining;
      logic [9:0] count;
      logic       ovf;
   } state_type;

   typedef struct packed {
      logic       valid;
      logic [7:0] byte_out;
      role_type   role;
      logic       kept;
      logic       apdu_end;
      logic [9:0] length;
      logic       overflow;
   } result_type;

   localparam state_type STATE_RESET = '{
      phase:     PH_CLA,
      ins:       8'd0,
      remaining: 8'd0,
      count:     10'd0,
      ovf:       1'b0
   };

endpackage

// ===== rtl/t0as_step.sv =====
// Per-transaction decode: next splitter state and result from the current state.
// Depends on t0as_pkg.
module t0as_step (
   input  t0as_pkg::state_type  state,
   input  t0as_pkg::mode_type   mode,
   input  logic [7:0]           byte_value,
   output t0as_pkg::state_type  state_next,
   output t0as_pkg::result_type result
);

   logic [7:0] ins_p1;
   logic [7:0] rem_dec;
   logic       at_cap;
   logic [9:0] count_kept;
   logic       ovf_kept;
   logic       keep;
   logic       ends;

   assign ins_p1     = state.ins + 8'd1;
   assign rem_dec    = state.remaining - 8'd1;
   assign at_cap     = (state.count >= t0as_pkg::LEN_CAP);
   assign count_kept = at_cap ? state.count : state.count + 10'd1;
   assign ovf_kept   = state.ovf | at_cap;

   always_comb begin
      state_next      = state;
      result.valid    = 1'b0;
      result.byte_out = byte_value;
      result.role     = t0as_pkg::ROLE_NONE;
      result.kept     = 1'b0;
      result.apdu_end = 1'b0;
      result.length   = state.count;
      result.overflow = state.ovf;
      keep            = 1'b0;
      ends            = 1'b0;

      case (mode)
         t0as_pkg::MODE_RESET: begin
            state_next = t0as_pkg::STATE_RESET;
         end
         t0as_pkg::MODE_BOUNDARY: begin
            result.valid    = 1'b1;
            result.byte_out = 8'd0;
            result.apdu_end = 1'b1;
            state_next      = t0as_pkg::STATE_RESET;
            state_next.ins  = state.ins;
         end
         t0as_pkg::MODE_BYTE: begin
            result.valid = 1'b1;
            case (state.phase)
               t0as_pkg::PH_INS: begin
                  keep             = 1'b1;
                  state_next.ins   = byte_value;
                  state_next.phase = t0as_pkg::PH_P1;
                  result.role      = t0as_pkg::ROLE_INS;
               end
               t0as_pkg::PH_P1: begin
                  keep             = 1'b1;
                  state_next.phase = t0as_pkg::PH_P2;
                  result.role      = t0as_pkg::ROLE_P1;
               end
               t0as_pkg::PH_P2: begin
                  keep             = 1'b1;
                  state_next.phase = t0as_pkg::PH_P3;
                  result.role      = t0as_pkg::ROLE_P2;
               end
               t0as_pkg::PH_P3: begin
                  keep                 = 1'b1;
                  state_next.remaining = byte_value;
                  state_next.phase     = t0as_pkg::PH_PROC;
                  result.role          = t0as_pkg::ROLE_P3;
               end
               t0as_pkg::PH_DATA: begin
                  keep                 = 1'b1;
                  state_next.remaining = rem_dec;
                  if (rem_dec == 8'd0) begin
                     state_next.phase = t0as_pkg::PH_PROC;
                  end
                  result.role = t0as_pkg::ROLE_DATA;
               end
               t0as_pkg::PH_DATA_ONE: begin
                  keep                 = 1'b1;
                  state_next.remaining = rem_dec;
                  state_next.phase     = t0as_pkg::PH_PROC;
                  result.role          = t0as_pkg::ROLE_DATA;
               end
               t0as_pkg::PH_PROC: begin
                  if (byte_value == t0as_pkg::NULL_BYTE) begin
                     result.role = t0as_pkg::ROLE_NULL;
                  end else if (byte_value == state.ins || byte_value == ins_p1 ||
                               byte_value == ~ins_p1) begin
                     state_next.phase = t0as_pkg::PH_DATA;
                     result.role      = t0as_pkg::ROLE_ACK_ALL;
                  end else if (byte_value == ~state.ins) begin
                     state_next.phase = t0as_pkg::PH_DATA_ONE;
                     result.role      = t0as_pkg::ROLE_ACK_ONE;
                  end else begin
                     keep             = 1'b1;
                     state_next.phase = t0as_pkg::PH_SW2;
                     result.role      = t0as_pkg::ROLE_SW1;
                  end
               end
               t0as_pkg::PH_SW2: begin
                  keep        = 1'b1;
                  ends        = 1'b1;
                  result.role = t0as_pkg::ROLE_SW2;
               end
               default: begin
                  keep             = 1'b1;
                  state_next.phase = t0as_pkg::PH_INS;
                  result.role      = t0as_pkg::ROLE_CLA;
               end
            endcase

            if (keep) begin
               result.kept      = 1'b1;
               result.length    = count_kept;
               result.overflow  = ovf_kept;
               state_next.count = count_kept;
               state_next.ovf   = ovf_kept;
            end
            // SW2 closes the APDU after the result has taken the final count
            if (ends) begin
               result.apdu_end      = 1'b1;
               state_next.phase     = t0as_pkg::PH_CLA;
               state_next.remaining = 8'd0;
               state_next.count     = 10'd0;
               state_next.ovf       = 1'b0;
            end
         end
         default: begin
            state_next = state;
         end
      endcase
   end

endmodule

// ===== rtl/t0_apdu_splitter.sv =====
// Throughput: one transaction per cycle while no result waits for the output slot;
// the single t0as_step update between input and result register sets that figure.
// Reset (synchronous, active high) returns to class-byte-expected with an empty APDU
// and instruction byte zero, and empties both registers.
// Top level: input register, splitter state, result register. Uses t0as_pkg, t0as_step.
module t0_apdu_splitter (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_mode,
   input  logic [7:0] req_byte_value,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_byte_out,
   output logic [3:0] rsp_role,
   output logic       rsp_kept,
   output logic       rsp_apdu_end,
   output logic [9:0] rsp_apdu_length,
   output logic       rsp_overflow
);

   logic                 in_valid_ff;
   t0as_pkg::mode_type   in_mode_ff;
   logic [7:0]           in_byte_ff;
   t0as_pkg::state_type  state_ff;
   t0as_pkg::state_type  state_in;
   t0as_pkg::result_type result;
   logic                 rsp_valid_ff;
   t0as_pkg::result_type rsp_ff;
   logic                 out_free;
   logic                 fire;

   t0as_step u_step (
      .state      (state_ff),
      .mode       (in_mode_ff),
      .byte_value (in_byte_ff),
      .state_next (state_in),
      .result     (result)
   );

   assign out_free  = !rsp_valid_ff || rsp_ready;
   // advance unless a result must wait for the output slot
   assign fire      = in_valid_ff && (!result.valid || out_free);
   assign req_ready = !in_valid_ff || fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_valid && req_ready) begin
         in_valid_ff <= 1'b1;
      end else if (fire) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_mode_ff <= t0as_pkg::mode_type'(req_mode);
         in_byte_ff <= req_byte_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= t0as_pkg::STATE_RESET;
      end else if (fire) begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (fire && result.valid) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire && result.valid) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_byte_out    = rsp_ff.byte_out;
   assign rsp_role        = rsp_ff.role;
   assign rsp_kept        = rsp_ff.kept;
   assign rsp_apdu_end    = rsp_ff.apdu_end;
   assign rsp_apdu_length = rsp_ff.length;
   assign rsp_overflow    = rsp_ff.overflow;

   a_phase_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff.phase))
      else $error("phase register not one-hot");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |-> !(fire && result.valid))
      else $error("pending result overwritten");

   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      (fire && result.valid && result.apdu_end) |=>
         (state_ff.count == 10'd0 && !state_ff.ovf &&
          state_ff.phase == t0as_pkg::PH_CLA))
      else $error("APDU not cleared after its last transaction");

   a_length_cap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_apdu_length <= t0as_pkg::LEN_CAP))
      else $error("APDU length beyond cap");

   a_boundary_shape: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_role == t0as_pkg::ROLE_NONE) |->
         (rsp_apdu_end && !rsp_kept && rsp_byte_out == 8'd0))
      else $error("malformed boundary result");

endmodule

// ===== sim/testbench.sv =====
// Testbench for t0_apdu_splitter: directed script plus random APDU traffic,
// every result checked against an in-bench APDU splitter predictor or the script.
// Depends on rtl/t0as_pkg.sv and rtl/t0_apdu_splitter.sv.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] MODE_UNKNOWN = 2'd3;
   localparam int CYCLE_LIMIT  = 600000;
   localparam int RANDOM_ITEMS = 1800;
   localparam int TAIL_CYCLES  = 10;

   typedef struct packed {
      logic [7:0]         value;
      t0as_pkg::role_type role;
      logic               kept;
      logic               last;
      logic [9:0]         length;
      logic               ovf;
   } byte_tag_type;

   typedef struct packed {
      logic [1:0]   mode;
      logic [7:0]   value;
      bit           typed;
      byte_tag_type want;
   } script_row_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [1:0] req_mode = t0as_pkg::MODE_BYTE;
   logic [7:0] req_byte_value = 8'h00;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [7:0] rsp_byte_out;
   logic [3:0] rsp_role;
   logic       rsp_kept;
   logic       rsp_apdu_end;
   logic [9:0] rsp_apdu_length;
   logic       rsp_overflow;

   t0_apdu_splitter dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_mode        (req_mode),
      .req_byte_value  (req_byte_value),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_byte_out    (rsp_byte_out),
      .rsp_role        (rsp_role),
      .rsp_kept        (rsp_kept),
      .rsp_apdu_end    (rsp_apdu_end),
      .rsp_apdu_length (rsp_apdu_length),
      .rsp_overflow    (rsp_overflow)
   );

   always #10ns clock = ~clock;

   // splitter predictor state
   t0as_pkg::phase_type split_phase = t0as_pkg::PH_CLA;
   logic [7:0]          split_ins   = 8'h00;
   logic [7:0]          split_left  = 8'h00;
   logic [9:0]          split_count = 10'd0;
   logic                split_ovf   = 1'b0;

   byte_tag_type   tags_due[$];
   script_row_type script[$];
   int             mismatches   = 0;
   int             results_seen = 0;
   int             items_sent   = 0;
   int             cycles       = 0;
   bit             calm_send    = 1'b0;
   bit             calm_recv    = 1'b0;
   bit             holdoff_done = 1'b0;
   int             holdoff_left = 0;
   int             stall_left   = 0;

   function automatic void clear_apdu();
      split_phase = t0as_pkg::PH_CLA;
      split_left  = 8'h00;
      split_count = 10'd0;
      split_ovf   = 1'b0;
   endfunction

   function automatic void count_kept();
      if (split_count < t0as_pkg::LEN_CAP) split_count++;
      else split_ovf = 1'b1;
   endfunction

   function automatic byte_tag_type make_tag(logic [7:0] v, t0as_pkg::role_type r, logic k,
                                             logic e);
      byte_tag_type t;
      t.value  = v;
      t.role   = r;
      t.kept   = k;
      t.last   = e;
      t.length = split_count;
      t.ovf    = split_ovf;
      return t;
   endfunction

   // Advance the predictor by one transaction; return 1 when it yields a result.
   function automatic bit split_step(input logic [1:0] m, input logic [7:0] b,
                                     output byte_tag_type t);
      logic [7:0] ins_inc;
      t = '0;
      ins_inc = split_ins + 8'd1;
      case (m)
         t0as_pkg::MODE_RESET: begin
            split_ins = 8'h00;
            clear_apdu();
            return 1'b0;
         end
         t0as_pkg::MODE_BOUNDARY: begin
            t = make_tag(8'h00, t0as_pkg::ROLE_NONE, 1'b0, 1'b1);
            clear_apdu();
            return 1'b1;
         end
         t0as_pkg::MODE_BYTE: ;
         default: return 1'b0;
      endcase
      case (split_phase)
         t0as_pkg::PH_INS: begin
            split_ins = b;
            count_kept();
            split_phase = t0as_pkg::PH_P1;
            t = make_tag(b, t0as_pkg::ROLE_INS, 1'b1, 1'b0);
         end
         t0as_pkg::PH_P1: begin
            count_kept();
            split_phase = t0as_pkg::PH_P2;
            t = make_tag(b, t0as_pkg::ROLE_P1, 1'b1, 1'b0);
         end
         t0as_pkg::PH_P2: begin
            count_kept();
            split_phase = t0as_pkg::PH_P3;
            t = make_tag(b, t0as_pkg::ROLE_P2, 1'b1, 1'b0);
         end
         t0as_pkg::PH_P3: begin
            count_kept();
            split_left = b;
            split_phase = t0as_pkg::PH_PROC;
            t = make_tag(b, t0as_pkg::ROLE_P3, 1'b1, 1'b0);
         end
         t0as_pkg::PH_DATA: begin
            count_kept();
            split_left = split_left - 8'd1;
            if (split_left == 8'h00) split_phase = t0as_pkg::PH_PROC;
            t = make_tag(b, t0as_pkg::ROLE_DATA, 1'b1, 1'b0);
         end
         t0as_pkg::PH_DATA_ONE: begin
            count_kept();
            split_left = split_left - 8'd1;
            split_phase = t0as_pkg::PH_PROC;
            t = make_tag(b, t0as_pkg::ROLE_DATA, 1'b1, 1'b0);
         end
         t0as_pkg::PH_PROC: begin
            if (b == t0as_pkg::NULL_BYTE) begin
               t = make_tag(b, t0as_pkg::ROLE_NULL, 1'b0, 1'b0);
            end else if (b == split_ins || b == ins_inc || b == ~ins_inc) begin
               split_phase = t0as_pkg::PH_DATA;
               t = make_tag(b, t0as_pkg::ROLE_ACK_ALL, 1'b0, 1'b0);
            end else if (b == ~split_ins) begin
               split_phase = t0as_pkg::PH_DATA_ONE;
               t = make_tag(b, t0as_pkg::ROLE_ACK_ONE, 1'b0, 1'b0);
            end else begin
               count_kept();
               split_phase = t0as_pkg::PH_SW2;
               t = make_tag(b, t0as_pkg::ROLE_SW1, 1'b1, 1'b0);
            end
         end
         t0as_pkg::PH_SW2: begin
            count_kept();
            t = make_tag(b, t0as_pkg::ROLE_SW2, 1'b1, 1'b1);
            clear_apdu();
         end
         default: begin
            count_kept();
            split_phase = t0as_pkg::PH_INS;
            t = make_tag(b, t0as_pkg::ROLE_CLA, 1'b1, 1'b0);
         end
      endcase
      return 1'b1;
   endfunction

   // Mostly short gaps, a few long ones.
   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Pick a status byte that the current instruction cannot read as a procedure byte.
   function automatic logic [7:0] status_byte();
      logic [7:0] b;
      logic [7:0] ins_inc;
      ins_inc = split_ins + 8'd1;
      do b = 8'($urandom_range(0, 255));
      while (b == t0as_pkg::NULL_BYTE || b == split_ins || b == ins_inc || b == ~ins_inc ||
             b == ~split_ins);
      return b;
   endfunction

   function automatic script_row_type plain_row(logic [1:0] m, logic [7:0] b);
      script_row_type s;
      s = '0;
      s.mode  = m;
      s.value = b;
      return s;
   endfunction

   function automatic script_row_type typed_row(logic [1:0] m, logic [7:0] b,
                                                t0as_pkg::role_type r, logic k, logic e,
                                                logic [9:0] len, logic o);
      script_row_type s;
      s = plain_row(m, b);
      s.typed = 1'b1;
      s.want  = '{value: (m == t0as_pkg::MODE_BOUNDARY) ? 8'h00 : b, role: r, kept: k,
                  last: e, length: len, ovf: o};
      return s;
   endfunction

   task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
      mismatches++;
      $display("mismatch at cycle %0d: %s got %0d, want %0d", cycles, what, got, want);
   endtask

   task automatic idle(int n);
      req_valid <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   task automatic send_item(input logic [1:0] m, input logic [7:0] b, input bit typed,
                            input byte_tag_type want);
      byte_tag_type t;
      int           g;
      req_valid      <= 1'b1;
      req_mode       <= m;
      req_byte_value <= b;
      do @(posedge clock); while (!req_ready);
      if (split_step(m, b, t)) tags_due.push_back(typed ? want : t);
      if (m != MODE_UNKNOWN) items_sent++;
      g = calm_send ? 0 : idle_len();
      if (g > 0) idle(g);
   endtask

   task automatic put_byte(logic [7:0] b);
      send_item(t0as_pkg::MODE_BYTE, b, 1'b0, '0);
   endtask

   task automatic wait_drained();
      idle(1);
      while (tags_due.size() != 0) @(posedge clock);
   endtask

   // One APDU driven by the predictor's phase; the long one overflows the length cap.
   task automatic send_apdu(bit long_one);
      int         steps;
      int         acks;
      int         r;
      logic [7:0] ins_inc;
      steps = 0;
      acks  = 0;
      put_byte(8'($urandom_range(0, 255)));
      put_byte(long_one ? 8'($urandom_range(0, 8'h5F)) : 8'($urandom_range(0, 255)));
      put_byte(8'($urandom_range(0, 255)));
      put_byte(8'($urandom_range(0, 255)));
      r = $urandom_range(0, 99);
      if (long_one) put_byte(8'h00);
      else if (r < 80) put_byte(8'($urandom_range(0, 6)));
      else if (r < 95) put_byte(8'($urandom_range(7, 40)));
      else put_byte(8'($urandom_range(0, 255)));
      while (split_phase != t0as_pkg::PH_CLA) begin
         if (split_phase == t0as_pkg::PH_PROC) begin
            steps++;
            ins_inc = split_ins + 8'd1;
            r = $urandom_range(0, 9);
            if (long_one) begin
               if (acks < 2) begin
                  acks++;
                  put_byte(split_ins);
               end else begin
                  put_byte(status_byte());
               end
            end else if (r < 2) begin
               put_byte(t0as_pkg::NULL_BYTE);
            end else if (r < 6 && split_left != 8'h00 && steps < 10) begin
               case ($urandom_range(0, 2))
                  0: put_byte(split_ins);
                  1: put_byte(ins_inc);
                  default: put_byte(~ins_inc);
               endcase
            end else if (r < 8 && split_left != 8'h00 && steps < 10) begin
               put_byte(~split_ins);
            end else begin
               put_byte(status_byte());
            end
         end else begin
            put_byte(8'($urandom_range(0, 255)));
         end
      end
   endtask

   // Cut an APDU short with a boundary or a reset.
   task automatic send_broken();
      repeat ($urandom_range(1, 7)) put_byte(8'($urandom_range(0, 255)));
      case ($urandom_range(0, 2))
         0: send_item(t0as_pkg::MODE_BOUNDARY, 8'($urandom_range(0, 255)), 1'b0, '0);
         1: send_item(t0as_pkg::MODE_RESET, 8'($urandom_range(0, 255)), 1'b0, '0);
         default: begin
            send_item(MODE_UNKNOWN, 8'($urandom_range(0, 255)), 1'b0, '0);
            send_item(t0as_pkg::MODE_BOUNDARY, 8'($urandom_range(0, 255)), 1'b0, '0);
         end
      endcase
   endtask

   task automatic send_noise();
      repeat ($urandom_range(1, 4))
         send_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)), 1'b0, '0);
      if (split_phase != t0as_pkg::PH_CLA)
         send_item(t0as_pkg::MODE_BOUNDARY, 8'($urandom_range(0, 255)), 1'b0, '0);
   endtask

   task automatic check_result();
      byte_tag_type want;
      results_seen++;
      if (tags_due.size() == 0) begin
         report_mismatch("unexpected transaction, role", 16'(rsp_role),
                         16'(t0as_pkg::ROLE_NONE));
         return;
      end
      want = tags_due.pop_front();
      if (rsp_byte_out !== want.value)
         report_mismatch("byte_out", 16'(rsp_byte_out), 16'(want.value));
      if (rsp_role !== want.role) report_mismatch("role", 16'(rsp_role), 16'(want.role));
      if (rsp_kept !== want.kept) report_mismatch("kept", 16'(rsp_kept), 16'(want.kept));
      if (rsp_apdu_end !== want.last)
         report_mismatch("apdu_end", 16'(rsp_apdu_end), 16'(want.last));
      if (rsp_apdu_length !== want.length)
         report_mismatch("apdu_length", 16'(rsp_apdu_length), 16'(want.length));
      if (rsp_overflow !== want.ovf)
         report_mismatch("overflow", 16'(rsp_overflow), 16'(want.ovf));
   endtask

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("testbench: FAIL");
         $finish;
      end
   end

   // Result side: random stalls, calm stretches, one long hold-off.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) check_result();
         if (!holdoff_done && results_seen >= 400) begin
            holdoff_done = 1'b1;
            holdoff_left = 300;
         end
         if ($urandom_range(0, 149) == 0) calm_recv = !calm_recv;
         if (holdoff_left > 0) begin
            holdoff_left--;
            rsp_ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            if (!calm_recv && $urandom_range(0, 99) < 30) stall_left = idle_len();
         end
      end
   end

   initial begin
      bit long_done;
      bit drain_done;
      int pick;
      long_done  = 1'b0;
      drain_done = 1'b0;

      // reset, empty boundary, then a full APDU with null, single and full acks
      script.push_back(typed_row(t0as_pkg::MODE_BOUNDARY, 8'hFF, t0as_pkg::ROLE_NONE,
                                 1'b0, 1'b1, 10'd0, 1'b0));
      script.push_back(typed_row(t0as_pkg::MODE_BYTE, 8'hFF, t0as_pkg::ROLE_CLA,
                                 1'b1, 1'b0, 10'd1, 1'b0));
      script.push_back(typed_row(t0as_pkg::MODE_BYTE, 8'hA4, t0as_pkg::ROLE_INS,
                                 1'b1, 1'b0, 10'd2, 1'b0));
      script.push_back(typed_row(t0as_pkg::MODE_BYTE, 8'h00, t0as_pkg::ROLE_P1,
                                 1'b1, 1'b0, 10'd3, 1'b0));
      script.push_back(typed_row(t0as_pkg::MODE_BYTE, 8'hFF, t0as_pkg::ROLE_P2,
                                 1'b1, 1'b0, 10'd4, 1'b0));
      script.push_back(typed_row(t0as_pkg::MODE_BYTE, 8'h02, t0as_pkg::ROLE_P3,
                                 1'b1, 1'b0, 10'd5, 1'b0));
      script.push_back(plain_row(MODE_UNKNOWN, 8'h55));
      script.push_back(typed_row(t0as_pkg::MODE_BYTE, 8'h60, t0as_pkg::ROLE_NULL,
                                 1'b0, 1'b0, 10'd5, 1'b0));
      script.push_back(typed_row(t0as_pkg::MODE_BYTE, 8'h5B, t0as_pkg::ROLE_ACK_ONE,
                                 1'b0, 1'b0, 10'd5, 1'b0));
      script.push_back(typed_row(t0as_pkg::MODE_BYTE, 8'h00, t0as_pkg::ROLE_DATA,
                                 1'b1, 1'b0, 10'd6, 1'b0));
      script.push_back(typed_row(t0as_pkg::MODE_BYTE, 8'hA4, t0as_pkg::ROLE_ACK_ALL,
                                 1'b0, 1'b0, 10'd6, 1'b0));
      script.push_back(typed_row(t0as_pkg::MODE_BYTE, 8'hFF, t0as_pkg::ROLE_DATA,
                                 1'b1, 1'b0, 10'd7, 1'b0));
      script.push_back(typed_row(t0as_pkg::MODE_BYTE, 8'h90, t0as_pkg::ROLE_SW1,
                                 1'b1, 1'b0, 10'd8, 1'b0));
      script.push_back(typed_row(t0as_pkg::MODE_BYTE, 8'h00, t0as_pkg::ROLE_SW2,
                                 1'b1, 1'b1, 10'd9, 1'b0));
      // instruction zero: inverted acks, then boundary mid-APDU and a reset
      script.push_back(plain_row(t0as_pkg::MODE_BYTE, 8'h00));
      script.push_back(plain_row(t0as_pkg::MODE_BYTE, 8'h00));
      script.push_back(plain_row(t0as_pkg::MODE_BYTE, 8'h7F));
      script.push_back(plain_row(t0as_pkg::MODE_BYTE, 8'h80));
      script.push_back(plain_row(t0as_pkg::MODE_BYTE, 8'h03));
      script.push_back(plain_row(t0as_pkg::MODE_BYTE, 8'hFF));
      script.push_back(plain_row(t0as_pkg::MODE_BYTE, 8'hAA));
      script.push_back(plain_row(t0as_pkg::MODE_BYTE, 8'hFE));
      script.push_back(plain_row(t0as_pkg::MODE_BYTE, 8'h55));
      script.push_back(plain_row(t0as_pkg::MODE_BYTE, 8'h01));
      script.push_back(plain_row(MODE_UNKNOWN, 8'h3C));
      script.push_back(plain_row(t0as_pkg::MODE_BOUNDARY, 8'h00));
      script.push_back(plain_row(t0as_pkg::MODE_BYTE, 8'h12));
      script.push_back(plain_row(t0as_pkg::MODE_RESET, 8'hFF));
      script.push_back(typed_row(t0as_pkg::MODE_BOUNDARY, 8'h00, t0as_pkg::ROLE_NONE,
                                 1'b0, 1'b1, 10'd0, 1'b0));

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (script[i]) send_item(script[i].mode, script[i].value, script[i].typed,
                                    script[i].want);
      wait_drained();

      items_sent = 0;
      while (items_sent < RANDOM_ITEMS) begin
         if (!long_done && items_sent > 600) begin
            long_done = 1'b1;
            send_apdu(1'b1);
            continue;
         end
         if (!drain_done && items_sent > 1200) begin
            drain_done = 1'b1;
            wait_drained();
         end
         if ($urandom_range(0, 5) == 0) calm_send = !calm_send;
         pick = $urandom_range(0, 99);
         if (pick < 75) send_apdu(1'b0);
         else if (pick < 87) send_broken();
         else send_noise();
      end

      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0 && tags_due.size() == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("testbench: FAIL");
      end
      $finish;
   end

endmodule
